[hdl/read_quality_trim_and_clip_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the read quality trim and clip block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef READ_QUALITY_TRIM_AND_CLIP_TOP_ASSERT_SVH
`define READ_QUALITY_TRIM_AND_CLIP_TOP_ASSERT_SVH

// same-cycle implication
`define RQTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RQTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rqtc_pkg.sv]
// ----------------------------------------------------------------------------
// rqtc_pkg
// Types and constants shared by the read quality trim and clip block.
// ----------------------------------------------------------------------------
package rqtc_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_QUALITY_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_CLIP_LEN      = 2'd1;
    localparam logic [1:0] REG_MIN_KEPT_LEN      = 2'd2;
    localparam logic [1:0] REG_QUALITY_OFFSET    = 2'd3;

    localparam logic [6:0]  RST_QUALITY_THRESHOLD = 7'd20;
    localparam logic [10:0] RST_MIN_CLIP_LEN      = 11'd10;
    localparam logic [10:0] RST_MIN_KEPT_LEN      = 11'd20;
    localparam logic [6:0]  RST_QUALITY_OFFSET    = 7'd33;

    localparam logic [10:0] TRIM_SAT = 11'h7FF;

    typedef enum logic [1:0] {
        MODE_TRIM       = 2'd0,
        MODE_CLIP_FIRST = 2'd1,
        MODE_CLIP_LAST  = 2'd2
    } clip_mode_t;

    typedef struct packed {
        logic [7:0]  qual_char;
        logic        last;
        logic [1:0]  clip_mode;
        logic [10:0] clip_count;
    } rqtc_in_t;

    typedef struct packed {
        logic [10:0]        trim_begin;
        logic [10:0]        trim_end;
        logic signed [11:0] clip_length;
        logic               pass;
    } rqtc_out_t;

    typedef struct packed {
        logic [6:0]  quality_threshold;
        logic [10:0] min_clip_len;
        logic [10:0] min_kept_len;
        logic [6:0]  quality_offset;
    } rqtc_cfg_t;

endpackage

[hdl/rqtc_cfg.sv]
// ----------------------------------------------------------------------------
// rqtc_cfg
// APB register file holding the trim thresholds and quality offset.
// ----------------------------------------------------------------------------
module rqtc_cfg
    import rqtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output rqtc_cfg_t         cfg
);

    rqtc_cfg_t  cfg_reg;
    rqtc_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_QUALITY_THRESHOLD: cfg_next.quality_threshold = pwdata[6:0];
                REG_MIN_CLIP_LEN:      cfg_next.min_clip_len      = pwdata[10:0];
                REG_MIN_KEPT_LEN:      cfg_next.min_kept_len      = pwdata[10:0];
                REG_QUALITY_OFFSET:    cfg_next.quality_offset    = pwdata[6:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_QUALITY_THRESHOLD: prdata = DATA_W'(cfg_reg.quality_threshold);
            REG_MIN_CLIP_LEN:      prdata = DATA_W'(cfg_reg.min_clip_len);
            REG_MIN_KEPT_LEN:      prdata = DATA_W'(cfg_reg.min_kept_len);
            REG_QUALITY_OFFSET:    prdata = DATA_W'(cfg_reg.quality_offset);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quality_threshold <= RST_QUALITY_THRESHOLD;
            cfg_reg.min_clip_len      <= RST_MIN_CLIP_LEN;
            cfg_reg.min_kept_len      <= RST_MIN_KEPT_LEN;
            cfg_reg.quality_offset    <= RST_QUALITY_OFFSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/rqtc_core.sv]
// ----------------------------------------------------------------------------
// rqtc_core
// Input register, per-read good-base tracking and registered result.
// ----------------------------------------------------------------------------
module rqtc_core
    import rqtc_pkg::*;
#(
    parameter int MAX_READ_LEN = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rqtc_cfg_t cfg,
    input  logic      item_valid,
    output logic      item_stall,
    input  rqtc_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output rqtc_out_t result
);

    localparam int PW = $clog2(MAX_READ_LEN + 1);
    localparam int CW = ((PW > 11) ? PW : 11) + 3;
    localparam logic [PW-1:0]        MAX_POS = PW'(MAX_READ_LEN);
    localparam logic signed [CW-1:0] ONE_S   = CW'(1);
    localparam logic signed [CW-1:0] SAT_S   = CW'(2047);

    logic            a_valid_reg, a_valid_next;
    rqtc_in_t        a_item_reg;
    logic            a_adv;
    logic            accept;

    logic [PW-1:0]   pos_reg, pos_next, pos_upd;
    logic [PW-1:0]   first_reg, first_next, first_upd;
    logic [PW-1:0]   lastg_reg, lastg_next, lastg_upd;
    logic            seen_reg, seen_next, seen_upd;

    logic            res_valid_reg, res_valid_next;
    rqtc_out_t       res_reg, res_calc;

    logic            good;
    logic            clip_mode;
    logic            mode_first;
    logic            ok;
    logic signed [CW-1:0] len_s, beg_s, end_s, cut_end_s, span_s;
    logic signed [CW-1:0] mc_s, mk_s, cnt_s, c_s, neg_c_s, other_s;

    assign a_adv      = a_valid_reg && (!a_item_reg.last || !res_valid_reg || !result_stall);
    assign item_stall = a_valid_reg && !a_adv;
    assign accept     = item_valid && !item_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // good-base tracking
    always_comb
    begin
        good      = {1'b0, a_item_reg.qual_char}
                    >= ({2'b0, cfg.quality_offset} + {2'b0, cfg.quality_threshold});
        pos_upd   = pos_reg;
        first_upd = first_reg;
        lastg_upd = lastg_reg;
        seen_upd  = seen_reg;
        if (pos_reg < MAX_POS)
        begin
            if (good && !seen_reg)
            begin
                seen_upd  = 1'b1;
                first_upd = pos_reg;
            end
            if (good && (pos_reg != '0))
            begin
                lastg_upd = pos_reg;
            end
            pos_upd = pos_reg + PW'(1);
        end
    end

    // end-of-read result
    always_comb
    begin
        case (a_item_reg.clip_mode)
            MODE_CLIP_FIRST:
            begin
                clip_mode  = 1'b1;
                mode_first = 1'b1;
            end
            MODE_CLIP_LAST:
            begin
                clip_mode  = 1'b1;
                mode_first = 1'b0;
            end
            default:
            begin
                clip_mode  = 1'b0;
                mode_first = 1'b0;
            end
        endcase

        len_s     = CW'(pos_upd);
        beg_s     = seen_upd ? CW'(first_upd) : len_s;
        end_s     = CW'(lastg_upd);
        cut_end_s = len_s - end_s - ONE_S;
        span_s    = end_s - beg_s;
        mc_s      = CW'(cfg.min_clip_len);
        mk_s      = CW'(cfg.min_kept_len);
        cnt_s     = CW'(a_item_reg.clip_count);
        c_s       = cnt_s - (mode_first ? beg_s : cut_end_s);
        neg_c_s   = -c_s;
        other_s   = mode_first ? cut_end_s : beg_s;

        if (clip_mode)
            ok = (span_s >= mc_s) && (c_s >= mc_s) && ((len_s - cnt_s) >= (other_s + mc_s));
        else
            ok = span_s > mk_s;

        res_calc.trim_begin  = (beg_s > SAT_S) ? TRIM_SAT : beg_s[10:0];
        res_calc.trim_end    = (cut_end_s > SAT_S) ? TRIM_SAT : cut_end_s[10:0];
        res_calc.pass        = ok;
        if (clip_mode && ok)
            res_calc.clip_length = mode_first ? c_s[11:0] : neg_c_s[11:0];
        else
            res_calc.clip_length = '0;
    end

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        res_valid_next = res_valid_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        lastg_next     = lastg_reg;
        seen_next      = seen_reg;

        if (accept)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        if (a_adv)
        begin
            if (a_item_reg.last)
            begin
                res_valid_next = 1'b1;
                pos_next       = '0;
                first_next     = '0;
                lastg_next     = '0;
                seen_next      = 1'b0;
            end
            else
            begin
                pos_next   = pos_upd;
                first_next = first_upd;
                lastg_next = lastg_upd;
                seen_next  = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            first_reg     <= '0;
            lastg_reg     <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            res_valid_reg <= res_valid_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            lastg_reg     <= lastg_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_item_reg <= item;
        if (a_adv && a_item_reg.last)
            res_reg <= res_calc;
    end

endmodule

[hdl/read_quality_trim_and_clip_top.sv]
// ----------------------------------------------------------------------------
// read_quality_trim_and_clip_top: quality end trimming with soft-clip checks
// Path: a transaction carrying last passes the input register and then the result
// register, which holds the result until it is taken.
// Throughput: 1 quality character per cycle; a last waits on a stalled result.
// Reset: async active low; clears tracking, pipeline valids, config defaults.
// ----------------------------------------------------------------------------
`include "read_quality_trim_and_clip_top_assert.svh"

module read_quality_trim_and_clip_top
    import rqtc_pkg::*;
#(
    parameter int MAX_READ_LEN = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  rqtc_in_t          item,
    output logic              result_valid,
    input  logic              result_stall,
    output rqtc_out_t         result
);

    localparam logic [10:0] TRIM_MAX =
        (MAX_READ_LEN > 2047) ? TRIM_SAT : 11'(MAX_READ_LEN);

    rqtc_cfg_t cfg;

    rqtc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rqtc_core #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `RQTC_ASSERT_SAME(a_stall_only_on_backpressure, item_stall, result_valid && result_stall, "input stalled without output backpressure")
    `RQTC_ASSERT_SAME(a_fail_has_no_clip, result_valid && !result.pass, result.clip_length == '0, "failed read carries a clip length")
    `RQTC_ASSERT_SAME(a_trim_begin_bound, result_valid, result.trim_begin <= TRIM_MAX, "trim_begin beyond read length limit")
    `RQTC_ASSERT_NEXT(a_cfg_write_lands, psel && penable && pwrite && (paddr[3:2] == REG_MIN_CLIP_LEN), cfg.min_clip_len == $past(pwdata[10:0]), "min_clip_len write lost")

endmodule
